>>> hdl/aesctr_pkg.sv
package aesctr_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] result_byte;
    logic       end_of_message;
  } out_item_t;

  typedef struct packed {
    logic busy;
    logic done;
  } core_status_t;

  typedef enum logic [1:0] {
    REG_KEY_HIGH = 2'd0,
    REG_KEY_LOW  = 2'd1,
    REG_IV_HIGH  = 2'd2,
    REG_IV_LOW   = 2'd3
  } cfg_reg_e;

  localparam logic [63:0] KEY_HIGH_RST = 64'h0123456789ABCDEF;
  localparam logic [63:0] KEY_LOW_RST  = 64'hFEDCBA9876543210;
  localparam logic [63:0] IV_HIGH_RST  = 64'h1122334455667788;
  localparam logic [63:0] IV_LOW_RST   = 64'h99AABBCCDDEEFF00;

  localparam logic [7:0] RCON_FIRST = 8'h01;
  localparam logic [7:0] REDUCE     = 8'h1b;
  localparam logic [3:0] LAST_ROUND = 4'd10;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] v);
    xtime = {v[6:0], 1'b0} ^ (v[7] ? REDUCE : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  // Next round key from the current one; byte 0 of the key is bit 127.
  function automatic logic [127:0] key_next(input logic [127:0] rk, input logic [7:0] rc);
    logic [31:0] t, n0, n1, n2, n3;
    t  = sub_word({rk[23:0], rk[31:24]}) ^ {rc, 24'h0};
    n0 = rk[127:96] ^ t;
    n1 = rk[95:64] ^ n0;
    n2 = rk[63:32] ^ n1;
    n3 = rk[31:0] ^ n2;
    key_next = {n0, n1, n2, n3};
  endfunction

  function automatic logic [127:0] aes_round(input logic [127:0] s, input logic [127:0] rk,
                                              input logic last);
    logic [7:0] t [16];
    logic [7:0] o [16];
    logic [7:0] a0, a1, a2, a3, all;
    logic [127:0] r;
    for (int c = 0; c < 4; c++) begin
      for (int b = 0; b < 4; b++) begin
        t[4*c+b] = SBOX[s[127-8*(4*((c+b)%4)+b) -: 8]];
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
      all = a0 ^ a1 ^ a2 ^ a3;
      if (last) begin
        o[4*c] = a0; o[4*c+1] = a1; o[4*c+2] = a2; o[4*c+3] = a3;
      end else begin
        o[4*c]   = a0 ^ all ^ xtime(a0 ^ a1);
        o[4*c+1] = a1 ^ all ^ xtime(a1 ^ a2);
        o[4*c+2] = a2 ^ all ^ xtime(a2 ^ a3);
        o[4*c+3] = a3 ^ all ^ xtime(a3 ^ a0);
      end
    end
    for (int i = 0; i < 16; i++) begin
      r[127-8*i -: 8] = o[i];
    end
    aes_round = r ^ rk;
  endfunction

endpackage

>>> hdl/aesctr_front.sv
module aesctr_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  aesctr_pkg::in_item_t in_item_i,
  output logic                 q_valid_o,
  input  logic                 q_pop_i,
  output aesctr_pkg::in_item_t q_item_o
);
  import aesctr_pkg::*;

  in_item_t   mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       push, pop;

  assign in_stall_o = (count_q == 2'd2);
  assign q_valid_o  = (count_q != 2'd0);
  assign q_item_o   = mem_q[rd_ptr_q];
  assign push       = in_valid_i && !in_stall_o;
  assign pop        = q_pop_i && q_valid_o;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      count_q <= count_q + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

>>> hdl/aesctr_core.sv
module aesctr_core (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [127:0]             key_i,
  input  logic [127:0]             block_i,
  output aesctr_pkg::core_status_t status_o,
  output logic [127:0]             result_o
);
  import aesctr_pkg::*;

  logic [127:0] state_q, rk_q, rk_next;
  logic [7:0]   rcon_q;
  logic [3:0]   round_q;
  logic         busy_q, done_q;

  assign rk_next  = key_next(rk_q, rcon_q);
  assign status_o = '{busy: busy_q, done: done_q};
  assign result_o = state_q;

  // One round per cycle, round key expanded alongside.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      state_q <= block_i ^ key_i;
      rk_q    <= key_i;
      rcon_q  <= RCON_FIRST;
    end else if (busy_q) begin
      state_q <= aes_round(state_q, rk_next, round_q == LAST_ROUND);
      rk_q    <= rk_next;
      rcon_q  <= xtime(rcon_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      round_q <= 4'd1;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q  <= 1'b1;
        round_q <= 4'd1;
      end else if (busy_q) begin
        round_q <= round_q + 4'd1;
        if (round_q == LAST_ROUND) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

>>> hdl/aes128_ctr_byte_stream.sv
// AES-128 counter mode over a byte stream; encryption and decryption are the
// same operation. Each accepted item carries one message byte and a last-byte
// flag and yields exactly one item: the byte XORed with the keystream byte at
// its place in the current 16-byte group. Within a group no byte waits for the
// round unit. At the first byte of each group the iterative round unit
// encrypts the counter (IV high 96 bits : 32-bit low word): a load step, ten
// rounds and a capture of the keystream. A two-entry input queue takes items
// while the round unit runs, and an output register holds a result while the
// sink stalls. The low counter word advances by one per completed group and
// wraps without carry; a last-byte item or any register write restarts the
// counter at the IV. Write registers only while the block is idle.
module aes128_ctr_byte_stream (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  aesctr_pkg::in_item_t  in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output aesctr_pkg::out_item_t out_item_o,
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_idx_i,
  input  logic [63:0]           cfg_wdata_i
);
  import aesctr_pkg::*;

  // configuration
  logic [63:0] key_high_q, key_low_q, iv_high_q, iv_low_q;

  // queue between front and back
  logic     q_valid, q_pop;
  in_item_t q_item;

  // back end
  logic [3:0]   pos_q;
  logic [31:0]  ctr_q;
  logic [127:0] ks_q;
  logic         ks_ok_q;
  logic         out_valid_q;
  out_item_t    out_q;

  core_status_t core_st;
  logic         core_start;
  logic [127:0] core_result;
  logic         out_free;

  aesctr_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .q_valid_o  (q_valid),
    .q_pop_i    (q_pop),
    .q_item_o   (q_item)
  );

  aesctr_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (core_start),
    .key_i    ({key_high_q, key_low_q}),
    .block_i  ({iv_high_q, iv_low_q[63:32], ctr_q}),
    .status_o (core_st),
    .result_o (core_result)
  );

  assign out_free   = !out_valid_q || !out_stall_i;
  // Launch keystream generation when a group's first byte is waiting.
  assign core_start = q_valid && (pos_q == 4'd0) && !ks_ok_q && !core_st.busy
                      && !core_st.done && !cfg_we_i;
  assign q_pop      = q_valid && ks_ok_q && out_free && !cfg_we_i;

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_high_q <= KEY_HIGH_RST;
      key_low_q  <= KEY_LOW_RST;
      iv_high_q  <= IV_HIGH_RST;
      iv_low_q   <= IV_LOW_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_KEY_HIGH: key_high_q <= cfg_wdata_i;
        REG_KEY_LOW:  key_low_q  <= cfg_wdata_i;
        REG_IV_HIGH:  iv_high_q  <= cfg_wdata_i;
        REG_IV_LOW:   iv_low_q   <= cfg_wdata_i;
        default:      ;
      endcase
    end
  end

  // Capture keystream and the output byte; payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (core_st.done) begin
      ks_q <= core_result;
    end
    if (q_pop) begin
      out_q.result_byte    <= q_item.data_byte ^ ks_q[8'd127 - {pos_q, 3'b000} -: 8];
      out_q.end_of_message <= q_item.last_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= 4'd0;
      ctr_q       <= IV_LOW_RST[31:0];
      ks_ok_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (q_pop) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      if (cfg_we_i) begin
        // Restart the message on any register write.
        pos_q   <= 4'd0;
        ks_ok_q <= 1'b0;
        ctr_q   <= (cfg_reg_e'(cfg_idx_i) == REG_IV_LOW) ? cfg_wdata_i[31:0] : iv_low_q[31:0];
      end else if (q_pop) begin
        if (q_item.last_byte) begin
          pos_q   <= 4'd0;
          ctr_q   <= iv_low_q[31:0];
          ks_ok_q <= 1'b0;
        end else begin
          pos_q <= pos_q + 4'd1;
          if (pos_q == 4'd15) begin
            ctr_q   <= ctr_q + 32'd1;
            ks_ok_q <= 1'b0;
          end
        end
      end else if (core_st.done) begin
        ks_ok_q <= 1'b1;
      end
    end
  end

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    core_start |-> !core_st.busy)
    else $error("round unit started while busy");

  a_pop_has_ks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> ks_ok_q && !core_st.busy)
    else $error("byte consumed without a keystream");

  a_done_sets_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    core_st.done && !cfg_we_i |=> ks_ok_q)
    else $error("keystream not marked ready after generation");

endmodule

>>> tb/tb_aes128_ctr_byte_stream.sv
module tb_aes128_ctr_byte_stream;
  import aesctr_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  in_item_t    in_item_i;
  logic        out_valid_o;
  logic        out_stall_i;
  out_item_t   out_item_o;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [63:0] cfg_wdata_i;

  aes128_ctr_byte_stream DUT (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_item_i,
    .out_valid_o, .out_stall_i, .out_item_o, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i
  );

  // S-box for the predictor, built at start as the multiplicative inverse in
  // GF(2^8) followed by the affine map
  logic [7:0] sbox_tbl [256];

  // predictor copy of the registers and the counter state
  logic [63:0]  key_hi_q, key_lo_q, iv_hi_q, iv_lo_q;
  logic [31:0]  ctr_word_q;
  logic [3:0]   byte_pos_q;
  logic [127:0] ks_block_q;

  out_item_t exp_bytes_q [$];
  int        n_errors;
  int        n_sent;
  int        n_checked;
  int        n_msgs;
  int        n_wraps;
  bit        quiet_phase;

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    p = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p ^= a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    end
    return p;
  endfunction

  function automatic logic [7:0] dbl8(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] rotl8(input logic [7:0] v, input int n);
    return (v << n) | (v >> (8 - n));
  endfunction

  // Encrypt one 128-bit block; byte 0 is bit 127.
  function automatic logic [127:0] aes_encrypt(input logic [127:0] key, input logic [127:0] blk);
    logic [31:0]  w [44];
    logic [31:0]  t;
    logic [7:0]   rc;
    logic [7:0]   s [16];
    logic [7:0]   u [16];
    logic [7:0]   a0, a1, a2, a3, x;
    logic [127:0] r;
    rc = 8'h01;
    for (int i = 0; i < 4; i++) w[i] = key[127-32*i -: 32];
    for (int i = 4; i < 44; i++) begin
      t = w[i-1];
      if (i % 4 == 0) begin
        t = {t[23:0], t[31:24]};
        t = {sbox_tbl[t[31:24]], sbox_tbl[t[23:16]], sbox_tbl[t[15:8]], sbox_tbl[t[7:0]]}
            ^ {rc, 24'h0};
        rc = dbl8(rc);
      end
      w[i] = w[i-4] ^ t;
    end
    for (int i = 0; i < 16; i++) s[i] = blk[127-8*i -: 8] ^ w[i/4][31-8*(i%4) -: 8];
    for (int rnd = 1; rnd <= 10; rnd++) begin
      for (int c = 0; c < 4; c++)
        for (int b = 0; b < 4; b++) u[4*c+b] = sbox_tbl[s[4*((c+b)%4)+b]];
      for (int c = 0; c < 4; c++) begin
        a0 = u[4*c]; a1 = u[4*c+1]; a2 = u[4*c+2]; a3 = u[4*c+3];
        if (rnd < 10) begin
          x = a0 ^ a1 ^ a2 ^ a3;
          s[4*c]   = a0 ^ x ^ dbl8(a0 ^ a1);
          s[4*c+1] = a1 ^ x ^ dbl8(a1 ^ a2);
          s[4*c+2] = a2 ^ x ^ dbl8(a2 ^ a3);
          s[4*c+3] = a3 ^ x ^ dbl8(a3 ^ a0);
        end else begin
          s[4*c] = a0; s[4*c+1] = a1; s[4*c+2] = a2; s[4*c+3] = a3;
        end
      end
      for (int i = 0; i < 16; i++) s[i] ^= w[4*rnd + i/4][31-8*(i%4) -: 8];
    end
    for (int i = 0; i < 16; i++) r[127-8*i -: 8] = s[i];
    return r;
  endfunction

  function automatic void restart_counter();
    ctr_word_q = iv_lo_q[31:0];
    byte_pos_q = 4'd0;
  endfunction

  // Predict the result of one message byte and advance the counter state.
  function automatic out_item_t crypt_byte(input in_item_t it);
    out_item_t o;
    if (byte_pos_q == 4'd0)
      ks_block_q = aes_encrypt({key_hi_q, key_lo_q}, {iv_hi_q, iv_lo_q[63:32], ctr_word_q});
    o.result_byte    = it.data_byte ^ ks_block_q[127-8*byte_pos_q -: 8];
    o.end_of_message = it.last_byte;
    if (it.last_byte) begin
      restart_counter();
      n_msgs++;
    end else begin
      byte_pos_q++;
      if (byte_pos_q == 4'd0) begin
        ctr_word_q++;
        if (ctr_word_q == 32'd0) n_wraps++;
      end
    end
    return o;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Random idling, about 14 in a hundred, off during the quiet phase.
  function automatic bit take_gap();
    return !quiet_phase && ($urandom_range(99) < 14);
  endfunction

  always @(posedge clk_i) begin
    out_stall_i <= rst_ni ? take_gap() : 1'b0;
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk_i) begin
    out_item_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (exp_bytes_q.size() == 0) begin
        $error("unexpected item: result_byte %h end_of_message %b",
               out_item_o.result_byte, out_item_o.end_of_message);
        n_errors++;
      end else begin
        e = exp_bytes_q.pop_front();
        n_checked++;
        if (out_item_o.result_byte !== e.result_byte) begin
          $error("result_byte: expected %h actual %h", e.result_byte, out_item_o.result_byte);
          n_errors++;
        end
        if (out_item_o.end_of_message !== e.end_of_message) begin
          $error("end_of_message: expected %b actual %b",
                 e.end_of_message, out_item_o.end_of_message);
          n_errors++;
        end
      end
    end
  end

  // Offer one item, hold it until accepted, queue its expectation.
  task automatic send_byte(input logic [7:0] d, input logic lst);
    in_item_t it;
    it.data_byte = d;
    it.last_byte = lst;
    while (take_gap()) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    exp_bytes_q.push_back(crypt_byte(it));
    n_sent++;
  endtask

  // Drain, settle, then write one register; every write restarts the counter.
  task automatic write_reg(input cfg_reg_e idx, input logic [63:0] val);
    in_valid_i <= 1'b0;
    while (exp_bytes_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_KEY_HIGH: key_hi_q = val;
      REG_KEY_LOW:  key_lo_q = val;
      REG_IV_HIGH:  iv_hi_q  = val;
      default:      iv_lo_q  = val;
    endcase
    restart_counter();
  endtask

  typedef struct {
    logic [7:0] d;
    logic       lst;
    bit         has_exp;
    logic [7:0] exp_byte;
  } dir_row_t;

  // Directed rows under an all-zero key and a zero IV: the first keystream
  // byte is then known (AES_K(0) byte 0 = 0x66 for all-zero key). Other rows
  // are checked only against the predictor.
  dir_row_t dir_rows [23] = '{
    '{8'h00, 1'b0, 1'b1, 8'h66}, '{8'hff, 1'b0, 1'b0, 8'h00}, '{8'h55, 1'b0, 1'b0, 8'h00},
    '{8'haa, 1'b0, 1'b0, 8'h00}, '{8'h01, 1'b1, 1'b0, 8'h00},
    // message restarted at the IV: same keystream byte again
    '{8'h00, 1'b0, 1'b1, 8'h66}, '{8'h80, 1'b0, 1'b0, 8'h00}, '{8'h7f, 1'b0, 1'b0, 8'h00},
    '{8'h10, 1'b0, 1'b0, 8'h00}, '{8'h20, 1'b0, 1'b0, 8'h00}, '{8'h30, 1'b0, 1'b0, 8'h00},
    '{8'h40, 1'b0, 1'b0, 8'h00}, '{8'h50, 1'b0, 1'b0, 8'h00}, '{8'h60, 1'b0, 1'b0, 8'h00},
    '{8'h70, 1'b0, 1'b0, 8'h00}, '{8'h90, 1'b0, 1'b0, 8'h00}, '{8'ha0, 1'b0, 1'b0, 8'h00},
    '{8'hb0, 1'b0, 1'b0, 8'h00}, '{8'hc0, 1'b0, 1'b0, 8'h00}, '{8'hd0, 1'b0, 1'b0, 8'h00},
    // crosses into the second group, then a last byte mid-group
    '{8'he0, 1'b0, 1'b0, 8'h00}, '{8'hf0, 1'b0, 1'b0, 8'h00}, '{8'hff, 1'b1, 1'b0, 8'h00}
  };

  initial begin
    int len;
    logic [7:0] ks;
    logic [127:0] ks_blk;
    n_errors = 0; n_sent = 0; n_checked = 0; n_msgs = 0; n_wraps = 0;
    quiet_phase = 1'b0;
    for (int i = 0; i < 256; i++) begin
      logic [7:0] inv, b;
      inv = 8'h00;
      for (int j = 1; j < 256; j++) if (gf_mul(i[7:0], j[7:0]) == 8'h01) inv = j[7:0];
      b = inv ^ rotl8(inv, 1) ^ rotl8(inv, 2) ^ rotl8(inv, 3) ^ rotl8(inv, 4) ^ 8'h63;
      sbox_tbl[i] = b;
    end
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_item_i   = '0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = REG_KEY_HIGH;
    cfg_wdata_i = '0;
    key_hi_q = KEY_HIGH_RST; key_lo_q = KEY_LOW_RST;
    iv_hi_q  = IV_HIGH_RST;  iv_lo_q  = IV_LOW_RST;
    restart_counter();
    ks_block_q = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset values: one short message
    for (int i = 0; i < 18; i++) send_byte(8'($urandom_range(255)), i == 17);

    // directed table under all-zero key and IV
    write_reg(REG_KEY_HIGH, 64'h0);
    write_reg(REG_KEY_LOW, 64'h0);
    write_reg(REG_IV_HIGH, 64'h0);
    write_reg(REG_IV_LOW, 64'h0);
    foreach (dir_rows[i]) begin
      if (dir_rows[i].has_exp) begin
        ks_blk = aes_encrypt({key_hi_q, key_lo_q}, {iv_hi_q, iv_lo_q[63:32], ctr_word_q});
        ks = ks_blk[127:120];
        if ((dir_rows[i].d ^ ks) !== dir_rows[i].exp_byte) begin
          $error("result_byte: expected %h actual %h", dir_rows[i].exp_byte, dir_rows[i].d ^ ks);
          n_errors++;
        end
      end
      send_byte(dir_rows[i].d, dir_rows[i].lst);
    end

    // all-ones extremes and the low-word wrap: start one group before wrap
    write_reg(REG_KEY_HIGH, '1);
    write_reg(REG_KEY_LOW, '1);
    write_reg(REG_IV_HIGH, '1);
    write_reg(REG_IV_LOW, 64'hffff_ffff_ffff_ffff);
    for (int i = 0; i < 40; i++) send_byte(8'($urandom_range(255)), i == 39);

    // random phases: new settings before each phase, a quiet stretch in one
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_KEY_HIGH, {$urandom, $urandom});
      write_reg(REG_KEY_LOW, {$urandom, $urandom});
      write_reg(REG_IV_HIGH, {$urandom, $urandom});
      write_reg(REG_IV_LOW, (ph == 2) ? {$urandom, 32'hffff_fffe} : {$urandom, $urandom});
      quiet_phase = (ph == 3);
      for (int m = 0; m < 5; m++) begin
        // mostly short messages, sometimes several groups long
        len = ($urandom_range(3) == 0) ? $urandom_range(33, 60) : $urandom_range(1, 20);
        for (int i = 0; i < len; i++) send_byte(8'($urandom_range(255)), i == len - 1);
      end
      // an unterminated tail left for the next register write to cut
      len = $urandom_range(0, 20);
      for (int i = 0; i < len; i++) send_byte(8'($urandom_range(255)), 1'b0);
    end
    quiet_phase = 1'b0;
    in_valid_i <= 1'b0;

    while (exp_bytes_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    $display("sent %0d bytes in %0d messages, checked %0d results, %0d counter wraps",
             n_sent, n_msgs, n_checked, n_wraps);
    if (n_errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

endmodule
